/* hdl/kmsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_pkg - shared types and helpers for the key matrix scanner
// Field widths of the stream payloads, config register indexes, the
// per-beat status struct and a small popcount used for the key tally.
// ----------------------------------------------------------------------------
package kmsd_pkg;

	localparam int TS_W       = 32;  // now_us / now_ms
	localparam int COL_W      = 10;  // col_bits / query_bits
	localparam int ROWSEL_W   = 4;   // query_row / row_select
	localparam int KCNT_W     = 8;   // key_count
	localparam int SETTLE_W   = 10;
	localparam int DEBOUNCE_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam int IN_DATA_W  = 80;  // 78 bits of fields, padded to bytes
	localparam int OUT_DATA_W = 32;  // 25 bits of fields, padded to bytes

	localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = SETTLE_W'(30);
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(5);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETTLE_DELAY_US = 1'b0,
		REG_DEBOUNCE_MS     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [ROWSEL_W-1:0] row_select;
		logic                columns_taken;
		logic                matrix_updated;
		logic                settled;
	} scan_status_t;

	function automatic logic [4:0] popcount16(input logic [15:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			n = n + 5'(v[i]);
		end
		return n;
	endfunction

endpackage

/* hdl/kmsd_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_scan - scan state, debounce timer and committed key matrix
// Holds the config registers and all scan state. One scan step is applied
// per step pulse; the committed matrix is read out at the query row.
// ----------------------------------------------------------------------------
module kmsd_scan #(
	parameter int ROWS = 16,
	parameter int COLS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [kmsd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   step,
	input  logic [kmsd_pkg::TS_W-1:0]              now_us,
	input  logic [kmsd_pkg::TS_W-1:0]              now_ms,
	input  logic [kmsd_pkg::COL_W-1:0]             col_bits,
	output kmsd_pkg::scan_status_t                 status,
	input  logic [kmsd_pkg::ROWSEL_W-1:0]          query_row,
	output logic [kmsd_pkg::COL_W-1:0]             query_bits,
	output logic [kmsd_pkg::KCNT_W-1:0]            key_count
);

	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W = $clog2(ROWS * COLS + 1);
	localparam int QW    = kmsd_pkg::COL_W;
	localparam int SW    = kmsd_pkg::ROWSEL_W;
	localparam int TW    = kmsd_pkg::TS_W;
	localparam int STW   = kmsd_pkg::SETTLE_W;
	localparam int DBW   = kmsd_pkg::DEBOUNCE_W;
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic [STW-1:0]   settle_q;
	logic [DBW-1:0]   debounce_q;
	logic [COLS-1:0]  sampled_q   [ROWS];
	logic [COLS-1:0]  committed_q [ROWS];
	logic [RW-1:0]    cur_q;
	logic             pending_q;
	logic [TW-1:0]    strobe_stamp_q;
	logic [TW-1:0]    deb_stamp_q;
	logic             complete_q;
	logic [CNT_W-1:0] sampled_cnt_q;
	logic [CNT_W-1:0] committed_cnt_q;

	logic [COLS-1:0]  row_old;
	logic [COLS-1:0]  row_new;
	logic             settle_ok;
	logic             deb_ok;
	logic             changed;
	logic             wrap;
	logic             commit;
	logic             complete_d;
	logic [CNT_W-1:0] cnt_new;

	always_comb begin
		row_old    = sampled_q[cur_q];
		row_new    = COLS'(col_bits);
		settle_ok  = (now_us - strobe_stamp_q) > TW'(settle_q);
		deb_ok     = (now_ms - deb_stamp_q) > TW'(debounce_q);
		changed    = !pending_q && (row_old != row_new);
		wrap       = !pending_q && (cur_q == LAST_ROW);
		// a change restarts the timer, so a wrap with a change never commits
		commit     = wrap && !changed && (complete_q || deb_ok);
		complete_d = changed ? 1'b0 : (wrap && deb_ok) ? 1'b1 : complete_q;
		cnt_new    = sampled_cnt_q
			- CNT_W'(kmsd_pkg::popcount16(16'(row_old)))
			+ CNT_W'(kmsd_pkg::popcount16(16'(row_new)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q   <= kmsd_pkg::SETTLE_RESET;
			debounce_q <= kmsd_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			case (kmsd_pkg::cfg_reg_t'(cfg_index))
				kmsd_pkg::REG_SETTLE_DELAY_US: settle_q   <= STW'(cfg_data);
				kmsd_pkg::REG_DEBOUNCE_MS:     debounce_q <= DBW'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				sampled_q[i]   <= '0;
				committed_q[i] <= '0;
			end
			cur_q           <= '0;
			pending_q       <= 1'b1;
			strobe_stamp_q  <= '0;
			deb_stamp_q     <= '0;
			complete_q      <= 1'b0;
			sampled_cnt_q   <= '0;
			committed_cnt_q <= '0;
		end else if (step) begin
			if (pending_q) begin
				if (settle_ok) begin
					pending_q <= 1'b0;
				end
			end else begin
				if (changed) begin
					sampled_q[cur_q] <= row_new;
					sampled_cnt_q    <= cnt_new;
					deb_stamp_q      <= now_ms;
				end
				complete_q <= complete_d;
				cur_q      <= wrap ? '0 : cur_q + RW'(1);
				if (commit) begin
					for (int i = 0; i < ROWS; i++) begin
						committed_q[i] <= sampled_q[i];
					end
					committed_cnt_q <= sampled_cnt_q;
				end
				// re-strobe for the next row
				pending_q      <= 1'b1;
				strobe_stamp_q <= now_us;
			end
		end
	end

	assign status.row_select     = SW'(cur_q);
	assign status.columns_taken  = !pending_q;
	assign status.matrix_updated = commit;
	assign status.settled        = pending_q ? complete_q : complete_d;

	always_comb begin
		query_bits = '0;
		if (32'(query_row) < ROWS) begin
			query_bits = QW'(committed_q[query_row[RW-1:0]]);
		end
	end

	assign key_count = kmsd_pkg::KCNT_W'(committed_cnt_q);

	a_commit_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && commit |-> !pending_q && cur_q == LAST_ROW)
		else $error("commit outside a row wrap");

	a_restrobe: assert property (@(posedge clk) disable iff (!arst_n)
		step && !pending_q |=> pending_q)
		else $error("read step did not restart the strobe");

	a_commit_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && commit |=> committed_cnt_q == sampled_cnt_q)
		else $error("committed key count out of step with sampled matrix");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(cur_q) && $stable(pending_q) && $stable(committed_cnt_q))
		else $error("scan state moved without a step");

	a_settled_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && changed |=> !complete_q)
		else $error("row change left debounce complete");

endmodule

/* hdl/key_matrix_scan_debounce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce - keyboard matrix scanner with global debounce
// Stream wrapper around the scan state: input register, one step, result
// register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one scan call per beat (timestamps, sampled columns and
//   the row to query); m_axis returns one result beat per scan call.
//   Config registers are written through cfg_we/cfg_index/cfg_data while
//   the block is idle; index 0 is settle_delay_us, index 1 is debounce_ms.
//   A beat is taken into the input register, then stepped into the result
//   register that drives m_axis. Throughput: one beat per cycle unless m_axis
//   stalls; the scan step is a single registered pass (two 32-bit timestamp
//   compares and a 10-bit popcount delta), so nothing iterates.
//   The input register keeps taking beats while a result waits on m_axis;
//   when m_axis stalls with the input register full, s_axis_tready drops
//   and the scan state holds.
//   Reset clears both matrices and the key count, selects row 0 with a
//   strobe pending from timestamp zero, and loads the config defaults
//   (30 us settle, 5 ms debounce).
// ----------------------------------------------------------------------------
module key_matrix_scan_debounce #(
	parameter int ROWS = 16,
	parameter int COLS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kmsd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// now_us[31:0], now_ms[63:32], col_bits[73:64], query_row[77:74]
	input  logic [kmsd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// row_select[3:0], columns_taken[4], matrix_updated[5], settled[6],
	// query_bits[16:7], key_count[24:17]
	output logic [kmsd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	localparam int TW = kmsd_pkg::TS_W;
	localparam int CW = kmsd_pkg::COL_W;
	localparam int SW = kmsd_pkg::ROWSEL_W;
	localparam int KW = kmsd_pkg::KCNT_W;
	localparam int PAD_W = kmsd_pkg::OUT_DATA_W - (SW + 3 + CW + KW);

	logic                  valid_s1;
	logic [TW-1:0]         now_us_s1;
	logic [TW-1:0]         now_ms_s1;
	logic [CW-1:0]         col_bits_s1;
	logic [SW-1:0]         query_row_s1;

	logic                  valid_s2;
	kmsd_pkg::scan_status_t status_s2;
	logic [SW-1:0]         query_row_s2;

	kmsd_pkg::scan_status_t status;
	logic [CW-1:0]         query_bits;
	logic [KW-1:0]         key_count;
	logic                  step;
	logic                  s_fire;

	assign step          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			now_us_s1    <= s_axis_tdata[31:0];
			now_ms_s1    <= s_axis_tdata[63:32];
			col_bits_s1  <= s_axis_tdata[73:64];
			query_row_s1 <= s_axis_tdata[77:74];
		end
	end

	kmsd_scan #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (step),
		.now_us     (now_us_s1),
		.now_ms     (now_ms_s1),
		.col_bits   (col_bits_s1),
		.status     (status),
		.query_row  (query_row_s2),
		.query_bits (query_bits),
		.key_count  (key_count)
	);

	// drop the result once taken, load the next one on a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_s2    <= status;
			query_row_s2 <= query_row_s1;
		end
	end

	// scan state only moves on a step, so it always matches the held beat
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {
		{PAD_W{1'b0}},
		key_count,
		query_bits,
		status_s2.settled,
		status_s2.matrix_updated,
		status_s2.columns_taken,
		status_s2.row_select
	};

endmodule

/* dv/kmsd_scan_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_scan_checker - scoreboard for the key matrix scanner
// Watches the config port and both stream channels. Each accepted scan call
// runs through a local model of the scan state; the result it produces is
// queued and compared field by field with the next result beat.
// ----------------------------------------------------------------------------
module kmsd_scan_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [kmsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kmsd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	// now_us[31:0], now_ms[63:32], col_bits[73:64], query_row[77:74]
	input  logic [kmsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// row_select[3:0], columns_taken[4], matrix_updated[5], settled[6],
	// query_bits[16:7], key_count[24:17]
	input  logic [kmsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output int                                 mismatches,
	output int                                 outstanding,
	output int                                 scan_calls,
	output int                                 column_reads,
	output int                                 commits,
	output logic [kmsd_pkg::ROWSEL_W-1:0]      model_row
);

	localparam int ROWS = 16;

	typedef struct packed {
		logic [1:0]                    pad;
		logic [kmsd_pkg::ROWSEL_W-1:0] query_row;
		logic [kmsd_pkg::COL_W-1:0]    col_bits;
		logic [kmsd_pkg::TS_W-1:0]     now_ms;
		logic [kmsd_pkg::TS_W-1:0]     now_us;
	} scan_call_t;

	typedef struct packed {
		logic [6:0]                    pad;
		logic [kmsd_pkg::KCNT_W-1:0]   key_count;
		logic [kmsd_pkg::COL_W-1:0]    query_bits;
		logic                          settled;
		logic                          matrix_updated;
		logic                          columns_taken;
		logic [kmsd_pkg::ROWSEL_W-1:0] row_select;
	} scan_result_t;

	logic [kmsd_pkg::COL_W-1:0]      committed [ROWS];
	logic [kmsd_pkg::COL_W-1:0]      sampled [ROWS];
	logic                            strobe_wait;
	logic [kmsd_pkg::TS_W-1:0]       strobe_t0;
	logic [kmsd_pkg::TS_W-1:0]       quiet_t0;
	logic                            quiet_done;
	logic [kmsd_pkg::SETTLE_W-1:0]   settle_us;
	logic [kmsd_pkg::DEBOUNCE_W-1:0] quiet_ms;
	scan_result_t                    pending_results [$];

	function automatic scan_result_t scan_call(input scan_call_t c);
		scan_result_t r;
		logic [kmsd_pkg::TS_W-1:0] since_strobe;
		logic [kmsd_pkg::TS_W-1:0] since_change;
		int keys;
		r = '0;
		r.row_select = model_row;
		since_strobe = c.now_us - strobe_t0;
		if (strobe_wait) begin
			if (since_strobe > kmsd_pkg::TS_W'(settle_us))
				strobe_wait = 1'b0;
		end else begin
			r.columns_taken = 1'b1;
			if (sampled[model_row] != c.col_bits) begin
				sampled[model_row] = c.col_bits;
				quiet_t0 = c.now_ms;
				quiet_done = 1'b0;
			end
			if (model_row == kmsd_pkg::ROWSEL_W'(ROWS - 1)) begin
				model_row = '0;
				since_change = c.now_ms - quiet_t0;
				if (!quiet_done && since_change > kmsd_pkg::TS_W'(quiet_ms))
					quiet_done = 1'b1;
				if (quiet_done) begin
					for (int i = 0; i < ROWS; i++)
						committed[i] = sampled[i];
					r.matrix_updated = 1'b1;
				end
			end else begin
				model_row = model_row + 1'b1;
			end
			strobe_wait = 1'b1;
			strobe_t0 = c.now_us;
		end
		keys = 0;
		for (int i = 0; i < ROWS; i++)
			keys += $countones(committed[i]);
		r.settled = quiet_done;
		if (int'(c.query_row) < ROWS)
			r.query_bits = committed[c.query_row];
		r.key_count = kmsd_pkg::KCNT_W'(keys);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		scan_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				committed[i] = '0;
				sampled[i] = '0;
			end
			model_row = '0;
			strobe_wait = 1'b1;
			strobe_t0 = '0;
			quiet_t0 = '0;
			quiet_done = 1'b0;
			settle_us = kmsd_pkg::SETTLE_RESET;
			quiet_ms = kmsd_pkg::DEBOUNCE_RESET;
			pending_results.delete();
			mismatches = 0;
			outstanding = 0;
			scan_calls = 0;
			column_reads = 0;
			commits = 0;
		end else begin
			if (cfg_we) begin
				case (kmsd_pkg::cfg_reg_t'(cfg_index))
					kmsd_pkg::REG_SETTLE_DELAY_US:
						settle_us = cfg_data[kmsd_pkg::SETTLE_W-1:0];
					kmsd_pkg::REG_DEBOUNCE_MS:
						quiet_ms = cfg_data[kmsd_pkg::DEBOUNCE_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = scan_call(scan_call_t'(s_axis_tdata));
				pending_results.push_back(want);
				scan_calls++;
				column_reads += int'(want.columns_taken);
				commits += int'(want.matrix_updated);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = scan_result_t'(m_axis_tdata);
				if (pending_results.size() == 0) begin
					$display("%0t ns: result beat with no call waiting, expected none actual 0x%0h",
						$time, m_axis_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("row_select", 32'(want.row_select), 32'(got.row_select));
					check_field("columns_taken", 32'(want.columns_taken),
						32'(got.columns_taken));
					check_field("matrix_updated", 32'(want.matrix_updated),
						32'(got.matrix_updated));
					check_field("settled", 32'(want.settled), 32'(got.settled));
					check_field("query_bits", 32'(want.query_bits), 32'(got.query_bits));
					check_field("key_count", 32'(want.key_count), 32'(got.key_count));
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for key_matrix_scan_debounce
// Drives scan calls with advancing timestamps and mostly steady key patterns
// so that strobes settle, rows are read and debounced matrices commit, mixed
// with random noise calls, across five register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;

	// no beat for this long means a hang; the slowest legal stretch is a run
	// of receiver stalls
	localparam int STALL_LIMIT = 5000;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [kmsd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [kmsd_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [kmsd_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [kmsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	int                              mismatches;
	int                              outstanding;
	int                              scan_calls;
	int                              column_reads;
	int                              commits;
	logic [kmsd_pkg::ROWSEL_W-1:0]   model_row;

	int                              src_idle_pct;
	int                              sink_stall_pct;
	int                              quiet_cycles;
	logic [kmsd_pkg::TS_W-1:0]       us_clock;
	logic [kmsd_pkg::TS_W-1:0]       ms_clock;
	logic [kmsd_pkg::SETTLE_W-1:0]   settle_now;
	logic [kmsd_pkg::DEBOUNCE_W-1:0] quiet_now;
	logic [kmsd_pkg::COL_W-1:0]      key_map [16];

	key_matrix_scan_debounce i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	kmsd_scan_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.scan_calls    (scan_calls),
		.column_reads  (column_reads),
		.commits       (commits),
		.model_row     (model_row)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [kmsd_pkg::IN_DATA_W-1:0] pack_call(
		input logic [kmsd_pkg::TS_W-1:0] now_us,
		input logic [kmsd_pkg::TS_W-1:0] now_ms,
		input logic [kmsd_pkg::COL_W-1:0] cols,
		input logic [kmsd_pkg::ROWSEL_W-1:0] query);
		return {2'b00, query, cols, now_ms, now_us};
	endfunction

	// enter and leave on a falling edge; tvalid stays up after the beat
	task automatic push_call(input logic [kmsd_pkg::IN_DATA_W-1:0] beat);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input kmsd_pkg::cfg_reg_t idx,
		input logic [kmsd_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == kmsd_pkg::REG_SETTLE_DELAY_US)
			settle_now = value[kmsd_pkg::SETTLE_W-1:0];
		else
			quiet_now = value[kmsd_pkg::DEBOUNCE_W-1:0];
	endtask

	// mostly well-formed scanning: steady keys, settle-sized time steps
	task automatic scan_random(input int count);
		logic [kmsd_pkg::TS_W-1:0]  us_step;
		logic [kmsd_pkg::COL_W-1:0] cols;
		int                         fill;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 10) begin
				push_call(pack_call($urandom, $urandom,
					kmsd_pkg::COL_W'($urandom_range(0, 1023)),
					kmsd_pkg::ROWSEL_W'($urandom_range(0, 15))));
			end else begin
				if ($urandom_range(0, 149) == 0) begin
					fill = $urandom_range(0, 3);
					for (int r = 0; r < 16; r++)
						key_map[r] = (fill == 0) ? '0 : (fill == 1) ? '1 :
							kmsd_pkg::COL_W'($urandom_range(0, 1023));
				end else if ($urandom_range(0, 59) == 0) begin
					key_map[$urandom_range(0, 15)] =
						kmsd_pkg::COL_W'($urandom_range(0, 1023));
				end
				case ($urandom_range(0, 5))
					0: us_step = kmsd_pkg::TS_W'(settle_now);
					1: us_step = kmsd_pkg::TS_W'(settle_now) + 1;
					2: us_step = kmsd_pkg::TS_W'($urandom_range(0, int'(settle_now)));
					default: us_step = kmsd_pkg::TS_W'(settle_now) + 1 + $urandom_range(0, 40);
				endcase
				us_clock = us_clock + us_step;
				ms_clock = ms_clock + $urandom_range(0, int'(quiet_now) / 8 + 2);
				cols = key_map[model_row];
				// contact chatter
				if ($urandom_range(0, 49) == 0)
					cols[$urandom_range(0, kmsd_pkg::COL_W - 1)] ^= 1'b1;
				push_call(pack_call(us_clock, ms_clock, cols,
					kmsd_pkg::ROWSEL_W'($urandom_range(0, 15))));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kmsd_pkg::REG_SETTLE_DELAY_US;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		quiet_cycles = 0;
		settle_now = kmsd_pkg::SETTLE_RESET;
		quiet_now = kmsd_pkg::DEBOUNCE_RESET;
		for (int r = 0; r < 16; r++)
			key_map[r] = kmsd_pkg::COL_W'($urandom_range(0, 1023));
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: settle boundary, timestamp wrap, field extremes
		push_call(pack_call(32'd30, 32'd0, '1, 4'd0));
		push_call(pack_call(32'd31, 32'd0, '1, 4'd15));
		push_call(pack_call(32'd31, 32'd0, '1, 4'd0));
		push_call(pack_call(32'd61, '1, '0, 4'd0));
		push_call(pack_call('1, '1, '0, 4'd15));
		push_call(pack_call('1, '1, '0, 4'd8));
		push_call(pack_call(32'd0, '1, '1, 4'd0));
		push_call(pack_call(32'd30, '1, '1, 4'd15));
		us_clock = 32'd30;
		ms_clock = '1;
		scan_random(180);
		drain();

		write_reg(kmsd_pkg::REG_SETTLE_DELAY_US, '0);
		write_reg(kmsd_pkg::REG_DEBOUNCE_MS, '0);
		src_idle_pct = 69;
		scan_random(190);
		drain();

		write_reg(kmsd_pkg::REG_SETTLE_DELAY_US, '1);
		write_reg(kmsd_pkg::REG_DEBOUNCE_MS, kmsd_pkg::CFG_DATA_W'(255));
		src_idle_pct = 0;
		sink_stall_pct = 69;
		scan_random(95);
		// hold off until every result is back, then resume
		drain();
		scan_random(95);
		drain();

		// upper bits of the debounce write fall outside the register
		write_reg(kmsd_pkg::REG_SETTLE_DELAY_US, kmsd_pkg::CFG_DATA_W'(7));
		write_reg(kmsd_pkg::REG_DEBOUNCE_MS, kmsd_pkg::CFG_DATA_W'(10'h302));
		src_idle_pct = 23;
		sink_stall_pct = 23;
		us_clock = 32'hFFFF_FF00;
		ms_clock = 32'hFFFF_FFF0;
		scan_random(190);
		drain();

		write_reg(kmsd_pkg::REG_SETTLE_DELAY_US,
			kmsd_pkg::CFG_DATA_W'($urandom_range(0, 63)));
		write_reg(kmsd_pkg::REG_DEBOUNCE_MS,
			kmsd_pkg::CFG_DATA_W'($urandom_range(0, 15)));
		src_idle_pct = 0;
		sink_stall_pct = 0;
		scan_random(190);
		drain();

		repeat (4) @(posedge clk);
		$display("Covered %0d scan calls over five register settings and idle patterns,",
			scan_calls);
		$display("with %0d column reads and %0d matrix commits.", column_reads, commits);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/kmsd_pkg.sv
hdl/kmsd_scan.sv
hdl/key_matrix_scan_debounce.sv
dv/kmsd_scan_checker.sv
dv/testbench.sv
